[design/qalu_pkg.sv]
// Shared types and default widths for the quaternion arithmetic unit.
// Has no dependencies; every other design file imports it.
`default_nettype none

package qalu_pkg;

    // Default component format: signed Q8.16
    localparam int QALU_COMP_WIDTH = 24;
    localparam int QALU_FRAC_BITS  = 16;

    // Operation codes carried with each transaction
    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_CONJ = 3'd3,
        OP_ROT  = 3'd4
    } t_op;

    // Per-stage control that travels down the pipeline with the data
    typedef struct packed {
        logic valid;
        t_op  op;
    } t_ctl;

endpackage

`default_nettype wire

[design/qalu_prod.sv]
// Product stage: sixteen component products (A*B, or A*A for rotation) and the
// linear operations add, subtract and conjugate. Depends on qalu_pkg.
`default_nettype none

module qalu_prod #(
    parameter int  COMP_WIDTH = qalu_pkg::QALU_COMP_WIDTH,
    parameter int  FRAC_BITS  = qalu_pkg::QALU_FRAC_BITS,
    localparam int PROD_W     = (2 * COMP_WIDTH - FRAC_BITS > COMP_WIDTH) ?
                                (2 * COMP_WIDTH - FRAC_BITS) : (COMP_WIDTH + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  qalu_pkg::t_ctl               i_ctl,
    input  logic signed [COMP_WIDTH-1:0] i_a [4],
    input  logic signed [COMP_WIDTH-1:0] i_b [4],
    output qalu_pkg::t_ctl               o_ctl,
    output logic signed [PROD_W-1:0]     o_p [4][4],
    output logic signed [COMP_WIDTH-1:0] o_lin [4],
    output logic                         o_lin_sat,
    output logic signed [COMP_WIDTH-1:0] o_v [3]
);
    import qalu_pkg::*;

    localparam int FULL_W = 2 * COMP_WIDTH;
    localparam int EXT_W  = COMP_WIDTH + 1;
    localparam logic signed [COMP_WIDTH-1:0] CMAX = {1'b0, {(COMP_WIDTH-1){1'b1}}};
    localparam logic signed [COMP_WIDTH-1:0] CMIN = {1'b1, {(COMP_WIDTH-1){1'b0}}};

    logic                         w_rot;
    logic signed [COMP_WIDTH-1:0] w_m    [4];
    logic signed [FULL_W-1:0]     w_mul  [4][4];
    logic signed [FULL_W-1:0]     w_full [4][4];
    logic signed [FULL_W-1:0]     w_shr  [4][4];
    logic signed [PROD_W-1:0]     w_p    [4][4];
    logic signed [EXT_W-1:0]      w_ext  [4];
    logic signed [COMP_WIDTH-1:0] w_lin  [4];
    logic [3:0]                   w_lin_ovf;

    qalu_pkg::t_ctl               r_ctl;
    logic signed [PROD_W-1:0]     r_p   [4][4];
    logic signed [COMP_WIDTH-1:0] r_lin [4];
    logic                         r_lin_sat;
    logic signed [COMP_WIDTH-1:0] r_v   [3];

    // Form products; rotation squares A and negates the diagonal x, y, z terms
    always_comb begin
        w_rot = (i_ctl.op == OP_ROT);
        for (int j = 0; j < 4; j++) begin
            w_m[j] = w_rot ? i_a[j] : i_b[j];
        end
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                w_mul[i][j]  = FULL_W'(i_a[i]) * FULL_W'(w_m[j]);
                w_full[i][j] = (w_rot && (i == j) && (i != 0)) ? -w_mul[i][j] : w_mul[i][j];
                w_shr[i][j]  = w_full[i][j] >>> FRAC_BITS;
                w_p[i][j]    = w_shr[i][j][PROD_W-1:0];
            end
        end
    end

    // Linear operations with saturation
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            case (i_ctl.op)
                OP_ADD:  w_ext[i] = EXT_W'(i_a[i]) + EXT_W'(i_b[i]);
                OP_SUB:  w_ext[i] = EXT_W'(i_a[i]) - EXT_W'(i_b[i]);
                OP_CONJ: w_ext[i] = (i == 0) ? EXT_W'(i_a[i]) : -EXT_W'(i_a[i]);
                default: w_ext[i] = '0;
            endcase
            w_lin_ovf[i] = (w_ext[i][COMP_WIDTH] != w_ext[i][COMP_WIDTH-1]);
            w_lin[i]     = w_lin_ovf[i] ? (w_ext[i][COMP_WIDTH] ? CMIN : CMAX)
                                        : w_ext[i][COMP_WIDTH-1:0];
        end
    end

    // Advance control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p       <= w_p;
            r_lin     <= w_lin;
            r_lin_sat <= |w_lin_ovf;
            for (int k = 0; k < 3; k++) begin
                r_v[k] <= i_b[k+1];
            end
        end
    end

    assign o_ctl     = r_ctl;
    assign o_p       = r_p;
    assign o_lin     = r_lin;
    assign o_lin_sat = r_lin_sat;
    assign o_v       = r_v;

endmodule

`default_nettype wire

[design/qalu_mix.sv]
// Sum stage: Hamilton product sums and the nine clipped rotation coefficients,
// plus selection of the non-rotate result. Depends on qalu_pkg.
`default_nettype none

module qalu_mix #(
    parameter int  COMP_WIDTH = qalu_pkg::QALU_COMP_WIDTH,
    parameter int  FRAC_BITS  = qalu_pkg::QALU_FRAC_BITS,
    localparam int PROD_W     = (2 * COMP_WIDTH - FRAC_BITS > COMP_WIDTH) ?
                                (2 * COMP_WIDTH - FRAC_BITS) : (COMP_WIDTH + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  qalu_pkg::t_ctl               i_ctl,
    input  logic signed [PROD_W-1:0]     i_p [4][4],
    input  logic signed [COMP_WIDTH-1:0] i_lin [4],
    input  logic                         i_lin_sat,
    input  logic signed [COMP_WIDTH-1:0] i_v [3],
    output qalu_pkg::t_ctl               o_ctl,
    output logic signed [COMP_WIDTH-1:0] o_res [4],
    output logic                         o_sat,
    output logic signed [COMP_WIDTH-1:0] o_c [9],
    output logic signed [COMP_WIDTH-1:0] o_v [3]
);
    import qalu_pkg::*;

    localparam int SUM_W = PROD_W + 2;
    localparam logic signed [COMP_WIDTH-1:0] CMAX = {1'b0, {(COMP_WIDTH-1){1'b1}}};
    localparam logic signed [COMP_WIDTH-1:0] CMIN = {1'b1, {(COMP_WIDTH-1){1'b0}}};

    function automatic logic f_ovf(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-COMP_WIDTH:0] hi;
        hi = v[SUM_W-1:COMP_WIDTH-1];
        return !((&hi) || !(|hi));
    endfunction

    function automatic logic signed [COMP_WIDTH-1:0] f_clip(input logic signed [SUM_W-1:0] v);
        logic ovf;
        ovf = f_ovf(v);
        return ovf ? (v[SUM_W-1] ? CMIN : CMAX) : v[COMP_WIDTH-1:0];
    endfunction

    logic signed [SUM_W-1:0]      w_e  [4][4];
    logic signed [SUM_W-1:0]      w_ms [4];
    logic signed [SUM_W-1:0]      w_cs [9];
    logic signed [COMP_WIDTH-1:0] w_mr [4];
    logic signed [COMP_WIDTH-1:0] w_c  [9];
    logic [3:0]                   w_m_ovf;
    logic [8:0]                   w_c_ovf;
    logic signed [COMP_WIDTH-1:0] w_res [4];
    logic                         w_sat;

    qalu_pkg::t_ctl               r_ctl;
    logic signed [COMP_WIDTH-1:0] r_res [4];
    logic                         r_sat;
    logic signed [COMP_WIDTH-1:0] r_c   [9];
    logic signed [COMP_WIDTH-1:0] r_v   [3];

    // Hamilton product sums and rotation coefficients
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                w_e[i][j] = SUM_W'(i_p[i][j]);
            end
        end
        w_ms[0] = w_e[0][0] - w_e[1][1] - w_e[2][2] - w_e[3][3];
        w_ms[1] = w_e[0][1] + w_e[1][0] + w_e[2][3] - w_e[3][2];
        w_ms[2] = w_e[0][2] - w_e[1][3] + w_e[2][0] + w_e[3][1];
        w_ms[3] = w_e[0][3] + w_e[1][2] - w_e[2][1] + w_e[3][0];
        // diagonal x, y, z squares arrive already negated
        w_cs[0] = w_e[2][2] + w_e[3][3];
        w_cs[1] = w_e[1][2] - w_e[0][3];
        w_cs[2] = w_e[0][2] + w_e[1][3];
        w_cs[3] = w_e[0][3] + w_e[1][2];
        w_cs[4] = w_e[1][1] + w_e[3][3];
        w_cs[5] = w_e[2][3] - w_e[0][1];
        w_cs[6] = w_e[1][3] - w_e[0][2];
        w_cs[7] = w_e[0][1] + w_e[2][3];
        w_cs[8] = w_e[1][1] + w_e[2][2];
        for (int i = 0; i < 4; i++) begin
            w_m_ovf[i] = f_ovf(w_ms[i]);
            w_mr[i]    = f_clip(w_ms[i]);
        end
        for (int k = 0; k < 9; k++) begin
            w_c_ovf[k] = f_ovf(w_cs[k]);
            w_c[k]     = f_clip(w_cs[k]);
        end
    end

    // Select the result for the operation; rotation finishes downstream
    always_comb begin
        case (i_ctl.op)
            OP_ADD, OP_SUB, OP_CONJ: begin
                w_res = i_lin;
                w_sat = i_lin_sat;
            end
            OP_MUL: begin
                w_res = w_mr;
                w_sat = |w_m_ovf;
            end
            OP_ROT: begin
                w_res = '{default: '0};
                w_sat = |w_c_ovf;
            end
            default: begin
                w_res = '{default: '0};
                w_sat = 1'b0;
            end
        endcase
    end

    // Advance control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= w_res;
            r_sat <= w_sat;
            r_c   <= w_c;
            r_v   <= i_v;
        end
    end

    assign o_ctl = r_ctl;
    assign o_res = r_res;
    assign o_sat = r_sat;
    assign o_c   = r_c;
    assign o_v   = r_v;

endmodule

`default_nettype wire

[design/qalu_vec.sv]
// Vector stages of rotation: coefficient-by-vector products, then row sums,
// doubling, vector add and final saturation; also the output register.
// Depends on qalu_pkg.
`default_nettype none

module qalu_vec #(
    parameter int  COMP_WIDTH = qalu_pkg::QALU_COMP_WIDTH,
    parameter int  FRAC_BITS  = qalu_pkg::QALU_FRAC_BITS,
    localparam int PROD_W     = (2 * COMP_WIDTH - FRAC_BITS > COMP_WIDTH) ?
                                (2 * COMP_WIDTH - FRAC_BITS) : (COMP_WIDTH + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en_mul,
    input  logic                         i_en_out,
    input  qalu_pkg::t_ctl               i_ctl,
    input  logic signed [COMP_WIDTH-1:0] i_res [4],
    input  logic                         i_sat,
    input  logic signed [COMP_WIDTH-1:0] i_c [9],
    input  logic signed [COMP_WIDTH-1:0] i_v [3],
    output qalu_pkg::t_ctl               o_mul_ctl,
    output qalu_pkg::t_ctl               o_ctl,
    output logic signed [COMP_WIDTH-1:0] o_r [4],
    output logic                         o_sat,
    output logic                         o_bad
);
    import qalu_pkg::*;

    localparam int FULL_W = 2 * COMP_WIDTH;
    localparam int ACC_W  = PROD_W + 4;
    localparam logic signed [COMP_WIDTH-1:0] CMAX = {1'b0, {(COMP_WIDTH-1){1'b1}}};
    localparam logic signed [COMP_WIDTH-1:0] CMIN = {1'b1, {(COMP_WIDTH-1){1'b0}}};

    logic signed [FULL_W-1:0]     w_full [9];
    logic signed [FULL_W-1:0]     w_shr  [9];
    logic signed [PROD_W-1:0]     w_f    [9];
    logic signed [ACC_W-1:0]      w_acc  [3];
    logic [ACC_W-COMP_WIDTH:0]    w_hi   [3];
    logic [2:0]                   w_ovf;
    logic signed [COMP_WIDTH-1:0] w_rv   [3];
    logic signed [COMP_WIDTH-1:0] w_r    [4];
    logic                         w_sat;
    logic                         w_bad;

    qalu_pkg::t_ctl               r_m_ctl;
    logic signed [PROD_W-1:0]     r_m_f   [9];
    logic signed [COMP_WIDTH-1:0] r_m_res [4];
    logic                         r_m_sat;
    logic signed [COMP_WIDTH-1:0] r_m_v   [3];

    qalu_pkg::t_ctl               r_o_ctl;
    logic signed [COMP_WIDTH-1:0] r_o_r [4];
    logic                         r_o_sat;
    logic                         r_o_bad;

    // Coefficient times vector component, floored
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            w_full[k] = FULL_W'(i_c[k]) * FULL_W'(i_v[k % 3]);
            w_shr[k]  = w_full[k] >>> FRAC_BITS;
            w_f[k]    = w_shr[k][PROD_W-1:0];
        end
    end

    // Row sums: 2 * (f0 + f1 + f2) + v, then clip
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_acc[r] = ((ACC_W'(r_m_f[3*r]) + ACC_W'(r_m_f[3*r+1]) + ACC_W'(r_m_f[3*r+2])) <<< 1)
                       + ACC_W'(r_m_v[r]);
            w_hi[r]  = w_acc[r][ACC_W-1:COMP_WIDTH-1];
            w_ovf[r] = !((&w_hi[r]) || !(|w_hi[r]));
            w_rv[r]  = w_ovf[r] ? (w_acc[r][ACC_W-1] ? CMIN : CMAX)
                                : w_acc[r][COMP_WIDTH-1:0];
        end
    end

    // Pick the rotation result or the one computed upstream
    always_comb begin
        w_bad = (r_m_ctl.op > OP_ROT);
        if (r_m_ctl.op == OP_ROT) begin
            w_r[0] = '0;
            w_r[1] = w_rv[0];
            w_r[2] = w_rv[1];
            w_r[3] = w_rv[2];
            w_sat  = r_m_sat || (|w_ovf);
        end else begin
            w_r   = r_m_res;
            w_sat = r_m_sat;
        end
    end

    // Advance control of both stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_ctl <= '0;
            r_o_ctl <= '0;
        end else begin
            if (i_en_mul) begin
                r_m_ctl <= i_ctl;
            end
            if (i_en_out) begin
                r_o_ctl <= r_m_ctl;
            end
        end
    end

    // Advance payload of the product stage
    always_ff @(posedge i_clk) begin
        if (i_en_mul) begin
            r_m_f   <= w_f;
            r_m_res <= i_res;
            r_m_sat <= i_sat;
            r_m_v   <= i_v;
        end
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (i_en_out) begin
            r_o_r   <= w_r;
            r_o_sat <= w_sat;
            r_o_bad <= w_bad;
        end
    end

    assign o_mul_ctl = r_m_ctl;
    assign o_ctl     = r_o_ctl;
    assign o_r       = r_o_r;
    assign o_sat     = r_o_sat;
    assign o_bad     = r_o_bad;

endmodule

`default_nettype wire

[design/quaternion_alu.sv]
// Quaternion arithmetic unit: add, subtract, Hamilton product, conjugate and
// vector rotation on signed fixed-point components. The pipeline has five
// register stages (input, sixteen-product bank, sums and rotation coefficients,
// nine-product bank, output); a transaction captured in the input register
// moves through the product, sum, nine-product and output registers in turn,
// and one transaction is taken every clock while o_stall is low; the two
// multiplier banks each hold one full set of products per stage. o_stall rises
// only when every stage holds a transaction and the output is stalled.
// FRAC_BITS is expected to be smaller than COMP_WIDTH. Top level; instantiates
// qalu_prod, qalu_mix and qalu_vec and depends on qalu_pkg.
`default_nettype none

module quaternion_alu #(
    parameter int COMP_WIDTH = qalu_pkg::QALU_COMP_WIDTH,
    parameter int FRAC_BITS  = qalu_pkg::QALU_FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [2:0]                   i_opcode,
    input  logic signed [COMP_WIDTH-1:0] i_a_w,
    input  logic signed [COMP_WIDTH-1:0] i_a_x,
    input  logic signed [COMP_WIDTH-1:0] i_a_y,
    input  logic signed [COMP_WIDTH-1:0] i_a_z,
    input  logic signed [COMP_WIDTH-1:0] i_b_w,
    input  logic signed [COMP_WIDTH-1:0] i_b_x,
    input  logic signed [COMP_WIDTH-1:0] i_b_y,
    input  logic signed [COMP_WIDTH-1:0] i_b_z,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [COMP_WIDTH-1:0] o_r_w,
    output logic signed [COMP_WIDTH-1:0] o_r_x,
    output logic signed [COMP_WIDTH-1:0] o_r_y,
    output logic signed [COMP_WIDTH-1:0] o_r_z,
    output logic                         o_saturated,
    output logic                         o_bad_opcode
);
    import qalu_pkg::*;

    localparam int PROD_W = (2 * COMP_WIDTH - FRAC_BITS > COMP_WIDTH) ?
                            (2 * COMP_WIDTH - FRAC_BITS) : (COMP_WIDTH + 1);

    t_ctl                         n_in_ctl;
    t_ctl                         r_in_ctl;
    logic signed [COMP_WIDTH-1:0] r_in_a [4];
    logic signed [COMP_WIDTH-1:0] r_in_b [4];

    logic w_en_in;
    logic w_en_prod;
    logic w_en_mix;
    logic w_en_mul;
    logic w_en_out;

    t_ctl                         w_prod_ctl;
    logic signed [PROD_W-1:0]     w_prod_p [4][4];
    logic signed [COMP_WIDTH-1:0] w_prod_lin [4];
    logic                         w_prod_lin_sat;
    logic signed [COMP_WIDTH-1:0] w_prod_v [3];

    t_ctl                         w_mix_ctl;
    logic signed [COMP_WIDTH-1:0] w_mix_res [4];
    logic                         w_mix_sat;
    logic signed [COMP_WIDTH-1:0] w_mix_c [9];
    logic signed [COMP_WIDTH-1:0] w_mix_v [3];

    t_ctl                         w_mul_ctl;
    t_ctl                         w_out_ctl;
    logic signed [COMP_WIDTH-1:0] w_out_r [4];
    logic                         w_out_sat;
    logic                         w_out_bad;

    // Stage enables: a stage loads when it is empty or its contents move on
    always_comb begin
        w_en_out  = !w_out_ctl.valid  || !i_stall;
        w_en_mul  = !w_mul_ctl.valid  || w_en_out;
        w_en_mix  = !w_mix_ctl.valid  || w_en_mul;
        w_en_prod = !w_prod_ctl.valid || w_en_mix;
        w_en_in   = !r_in_ctl.valid   || w_en_prod;
    end

    assign o_stall = !w_en_in;

    // Capture the incoming transaction
    always_comb begin
        n_in_ctl.valid = i_valid;
        n_in_ctl.op    = t_op'(i_opcode);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_ctl <= '0;
        end else if (w_en_in) begin
            r_in_ctl <= n_in_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_in) begin
            r_in_a[0] <= i_a_w;
            r_in_a[1] <= i_a_x;
            r_in_a[2] <= i_a_y;
            r_in_a[3] <= i_a_z;
            r_in_b[0] <= i_b_w;
            r_in_b[1] <= i_b_x;
            r_in_b[2] <= i_b_y;
            r_in_b[3] <= i_b_z;
        end
    end

    qalu_prod #(
        .COMP_WIDTH (COMP_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_prod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en_prod),
        .i_ctl     (r_in_ctl),
        .i_a       (r_in_a),
        .i_b       (r_in_b),
        .o_ctl     (w_prod_ctl),
        .o_p       (w_prod_p),
        .o_lin     (w_prod_lin),
        .o_lin_sat (w_prod_lin_sat),
        .o_v       (w_prod_v)
    );

    qalu_mix #(
        .COMP_WIDTH (COMP_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mix (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en_mix),
        .i_ctl     (w_prod_ctl),
        .i_p       (w_prod_p),
        .i_lin     (w_prod_lin),
        .i_lin_sat (w_prod_lin_sat),
        .i_v       (w_prod_v),
        .o_ctl     (w_mix_ctl),
        .o_res     (w_mix_res),
        .o_sat     (w_mix_sat),
        .o_c       (w_mix_c),
        .o_v       (w_mix_v)
    );

    qalu_vec #(
        .COMP_WIDTH (COMP_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_vec (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en_mul  (w_en_mul),
        .i_en_out  (w_en_out),
        .i_ctl     (w_mix_ctl),
        .i_res     (w_mix_res),
        .i_sat     (w_mix_sat),
        .i_c       (w_mix_c),
        .i_v       (w_mix_v),
        .o_mul_ctl (w_mul_ctl),
        .o_ctl     (w_out_ctl),
        .o_r       (w_out_r),
        .o_sat     (w_out_sat),
        .o_bad     (w_out_bad)
    );

    assign o_valid      = w_out_ctl.valid;
    assign o_r_w        = w_out_r[0];
    assign o_r_x        = w_out_r[1];
    assign o_r_y        = w_out_r[2];
    assign o_r_z        = w_out_r[3];
    assign o_saturated  = w_out_sat;
    assign o_bad_opcode = w_out_bad;

`ifndef SYNTH
    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // Backpressure only when the output itself is stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while output is free");

    // Backpressure only when every stage is occupied
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_ctl.valid && w_prod_ctl.valid && w_mix_ctl.valid
                     && w_mul_ctl.valid && w_out_ctl.valid))
        else $error("input stalled with a bubble in the pipeline");

    // A bad opcode gives an all-zero, unsaturated result
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad_opcode) |-> (o_r_w == '0 && o_r_x == '0 && o_r_y == '0
                                       && o_r_z == '0 && !o_saturated))
        else $error("bad opcode with nonzero result");
`endif

endmodule

`default_nettype wire
